// ===== src/tcd_pkg.sv =====
// Shared types and constants for the toy CPU instruction executor.
// Holds memory sizing, opcodes, datapath command and status structs.
// No dependencies.
package tcd_pkg;

  localparam int MEM_BYTES = 32768;
  localparam int MEM_AW    = $clog2(MEM_BYTES);

  // Configuration register index (byte address / 4).
  localparam logic [0:0] REG_PROGRAM_LENGTH = 1'b0;

  // Opcodes.
  localparam logic [7:0] OP_NOP = 8'd0;
  localparam logic [7:0] OP_MOV = 8'd1;
  localparam logic [7:0] OP_ADD = 8'd2;
  localparam logic [7:0] OP_SUB = 8'd3;
  localparam logic [7:0] OP_MUL = 8'd4;
  localparam logic [7:0] OP_DIV = 8'd5;
  localparam logic [7:0] OP_AND = 8'd6;
  localparam logic [7:0] OP_OR  = 8'd7;
  localparam logic [7:0] OP_NOT = 8'd8;
  localparam logic [7:0] OP_CMP = 8'd9;
  localparam logic [7:0] OP_JMP = 8'd10;
  localparam logic [7:0] OP_IN  = 8'd11;
  localparam logic [7:0] OP_OUT = 8'd12;

  // Jump conditions.
  localparam logic [3:0] JC_ALWAYS = 4'd0;
  localparam logic [3:0] JC_EQ     = 4'd1;
  localparam logic [3:0] JC_GT     = 4'd2;
  localparam logic [3:0] JC_LT     = 4'd3;

  // Compare flag codes.
  localparam logic [1:0] FLAG_EQ = 2'b00;
  localparam logic [1:0] FLAG_GT = 2'b01;
  localparam logic [1:0] FLAG_LT = 2'b11;

  // Highest directly used register; above it a register holds an address.
  localparam logic [3:0] REG_DIRECT_MAX = 4'd4;
  localparam logic [3:0] REG_MAX        = 4'd8;

  // Memory address base select.
  localparam logic [2:0] MA_PC   = 3'd0;
  localparam logic [2:0] MA_REG  = 3'd1;
  localparam logic [2:0] MA_IMM  = 3'd2;
  localparam logic [2:0] MA_LOAD = 3'd3;
  localparam logic [2:0] MA_CLR  = 3'd4;

  // Memory write data select.
  localparam logic [1:0] WD_ZERO = 2'd0;
  localparam logic [1:0] WD_LOAD = 2'd1;
  localparam logic [1:0] WD_HI   = 2'd2;
  localparam logic [1:0] WD_LO   = 2'd3;

  // Capture targets for memory or register file read data.
  localparam logic [3:0] CAP_NONE = 4'd0;
  localparam logic [3:0] CAP_OP   = 4'd1;
  localparam logic [3:0] CAP_RB   = 4'd2;
  localparam logic [3:0] CAP_IHI  = 4'd3;
  localparam logic [3:0] CAP_ILO  = 4'd4;
  localparam logic [3:0] CAP_AREG = 4'd5;
  localparam logic [3:0] CAP_AHI  = 4'd6;
  localparam logic [3:0] CAP_ALO  = 4'd7;
  localparam logic [3:0] CAP_BREG = 4'd8;
  localparam logic [3:0] CAP_BHI  = 4'd9;
  localparam logic [3:0] CAP_BLO  = 4'd10;

  typedef struct packed {
    logic [2:0] maddr_sel;
    logic [1:0] moff;
    logic       mwe;
    logic [1:0] wsel;
    logic [3:0] ridx;
    logic       rf_we;
    logic       rf_imm;
    logic [3:0] cap;
    logic       b_imm;
    logic       exec;
    logic       div_start;
    logic       div_cap;
    logic       ir_upd;
    logic       ip_upd;
    logic       in_take;
    logic       step_clr;
    logic       out_load;
    logic       clr_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] op;
    logic [3:0] m;
    logic [3:0] n;
    logic       finished;
    logic       clr_done;
    logic       div_done;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== src/toy_cpu_instruction_executor.sv =====
// Channel | Dir | Handshake              | Payload
// in_     | in  | in_tvalid/in_tready    | tuser mode, tdata load/in fields
// out_    | out | out_tvalid/out_tready  | tdata register result, tlast eighth
// cfg_    | in  | APB psel/penable       | program_length at address 0
//
// A load beat is accepted in S_IDLE and written to memory in S_LOAD. A step goes
// straight to the 8 result beats once ip has reached the program length;
// otherwise it runs the accept, the fetch of the 4 instruction bytes through
// the single memory port, decode, the operand reads, execute (a divide waits
// on the bit-serial divider), write-back, the ip update, then 8 result beats.
// After reset a clearing pass writes zero to all 32768 memory bytes, one per
// cycle, before the first beat is accepted. Output stalls hold the result
// beats; input is taken only between items.
// Top level of the toy CPU; uses tcd_pkg, tcd_ctrl, tcd_dp.
module toy_cpu_instruction_executor import tcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // load_address, load_byte, in_value, pad
  input  logic        in_tuser,    // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // ip_now, flag_now, ir_now, reg_number,
                                   // reg_value, out_valid, out_value, finished
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [15:0] plen_r;
  logic        in_fire, cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
    end else if (cfg_wr && (cfg_paddr[2:2] == REG_PROGRAM_LENGTH)) begin
      plen_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2:2] == REG_PROGRAM_LENGTH) ? {16'd0, plen_r} : 32'd0;
  assign in_fire    = in_tvalid && in_tready;

  tcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_mode  (in_tuser),
    .stat     (stat),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  tcd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .plen            (plen_r),
    .in_load_address (in_tdata[14:0]),
    .in_load_byte    (in_tdata[22:15]),
    .in_in_value     (in_tdata[38:23]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_data        (out_tdata),
    .out_last        (out_tlast)
  );

  // A step occupies the block: no new beat the cycle after one is taken.
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> !in_tready)
    else $error("input accepted right after a step");

  // The compare flag only ever holds less, equal or greater.
  a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:16] != 2'b10))
    else $error("invalid compare flag");

  // The last beat reports register 8.
  a_last_reg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[37:34] == REG_MAX))
    else $error("last beat does not report register 8");

  // A program length write reads back on the next cycle.
  a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (cfg_paddr[2:2] == REG_PROGRAM_LENGTH)) |=>
      ((cfg_paddr[2:2] != REG_PROGRAM_LENGTH) ||
       (cfg_prdata[15:0] == $past(cfg_pwdata[15:0]))))
    else $error("program length readback mismatch");

endmodule

// ===== src/tcd_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module tcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/tcd_div.sv =====
// Iterative signed 16-bit divider, one quotient bit per cycle.
// Truncates toward zero; a zero divisor gives a zero quotient. Uses tcd_pkg.
module tcd_div import tcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic [16:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] mb_r;
  logic        neg_r, bz_r;
  logic [3:0]  cnt_r;
  logic        busy_r, done_r;
  logic [16:0] shifted;
  logic [15:0] mag_a, mag_b;

  assign mag_a   = dividend[15] ? (16'd0 - dividend) : dividend;
  assign mag_b   = divisor[15]  ? (16'd0 - divisor)  : divisor;
  assign shifted = {rem_r[15:0], quo_r[15]};

  always_comb begin
    if (shifted >= {1'b0, mb_r}) begin
      rem_nxt = shifted - {1'b0, mb_r};
      quo_nxt = {quo_r[14:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      quo_nxt = {quo_r[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= mag_a;
      mb_r  <= mag_b;
      neg_r <= dividend[15] ^ divisor[15];
      bz_r  <= (divisor == 16'd0);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = bz_r ? 16'd0 : (neg_r ? (16'd0 - quo_r) : quo_r);

endmodule

// ===== src/tcd_ctrl.sv =====
// Controller state machine of the toy CPU: fetch, operand reads, execute,
// write-back and result beats. Drives the datapath by dp_cmd_t. Uses tcd_pkg.
module tcd_ctrl import tcd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     in_mode,
  input  dp_stat_t stat,
  output logic     in_ready,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_LOAD = 5'd2;
  localparam logic [4:0] S_F0   = 5'd3;
  localparam logic [4:0] S_F1   = 5'd4;
  localparam logic [4:0] S_F2   = 5'd5;
  localparam logic [4:0] S_F3   = 5'd6;
  localparam logic [4:0] S_F4   = 5'd7;
  localparam logic [4:0] S_DEC  = 5'd8;
  localparam logic [4:0] S_MVI  = 5'd9;
  localparam logic [4:0] S_O0   = 5'd10;
  localparam logic [4:0] S_O1   = 5'd11;
  localparam logic [4:0] S_O2   = 5'd12;
  localparam logic [4:0] S_EX   = 5'd13;
  localparam logic [4:0] S_DV   = 5'd14;
  localparam logic [4:0] S_W0   = 5'd15;
  localparam logic [4:0] S_W1   = 5'd16;
  localparam logic [4:0] S_IPUP = 5'd17;
  localparam logic [4:0] S_RES  = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic       rd_b_r, rd_b_nxt;
  logic       wimm_r, wimm_nxt;
  logic [2:0] k_r, k_nxt;

  logic       bad, active, is_mov, is_alu, is_cmp, is_in, is_div, movi, swap;
  logic       need_a, need_b, need_wb;
  logic [3:0] a_idx, dst_idx, opnd_idx, k_idx;
  logic [4:0] after_opnd;

  // Instruction decode from the fetched opcode and register byte.
  always_comb begin
    is_mov  = (stat.op == OP_MOV);
    is_alu  = stat.op inside {[OP_ADD:OP_NOT]};
    is_cmp  = (stat.op == OP_CMP);
    is_in   = (stat.op == OP_IN);
    bad     = (stat.op inside {[OP_MOV:OP_OUT]}) && (stat.op != OP_JMP) &&
              ((stat.m > REG_MAX) || (stat.n > REG_MAX));
    active  = !bad && (stat.op inside {[OP_MOV:OP_CMP], OP_IN, OP_OUT});
    movi    = is_mov && (stat.n == 4'd0);
    swap    = (stat.op inside {[OP_AND:OP_NOT]}) && (stat.m == 4'd0) &&
              (stat.n != 4'd0);
    is_div  = active && (stat.op == OP_DIV);
    a_idx   = (is_mov || swap) ? stat.n : stat.m;
    dst_idx = swap ? stat.n : stat.m;
    need_a  = active && !movi && !is_in;
    need_b  = active && (is_alu || is_cmp) && !swap && (stat.n != 4'd0);
    need_wb = active && ((is_mov && !movi) || is_alu || is_in);
  end

  assign opnd_idx   = rd_b_r ? stat.n : a_idx;
  assign k_idx      = {1'b0, k_r} + 4'd1;
  assign after_opnd = (!rd_b_r && need_b) ? S_O0 : S_EX;

  always_comb begin
    state_nxt = state_r;
    rd_b_nxt  = rd_b_r;
    wimm_nxt  = wimm_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.b_imm = !need_b;
    case (state_r)
      S_CLR: begin
        cmd.maddr_sel = MA_CLR;
        cmd.wsel      = WD_ZERO;
        cmd.mwe       = !stat.clr_done;
        cmd.clr_inc   = !stat.clr_done;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.in_take = 1'b1;
          if (in_mode) begin
            cmd.step_clr = 1'b1;
            state_nxt    = stat.finished ? S_RES : S_F0;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.maddr_sel = MA_LOAD;
        cmd.wsel      = WD_LOAD;
        cmd.mwe       = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_F0: begin
        cmd.maddr_sel = MA_PC;
        state_nxt     = S_F1;
      end
      S_F1: begin
        cmd.maddr_sel = MA_PC;
        cmd.moff      = 2'd1;
        cmd.cap       = CAP_OP;
        state_nxt     = S_F2;
      end
      S_F2: begin
        cmd.maddr_sel = MA_PC;
        cmd.moff      = 2'd2;
        cmd.cap       = CAP_RB;
        state_nxt     = S_F3;
      end
      S_F3: begin
        cmd.maddr_sel = MA_PC;
        cmd.moff      = 2'd3;
        cmd.cap       = CAP_IHI;
        state_nxt     = S_F4;
      end
      S_F4: begin
        cmd.cap   = CAP_ILO;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.ir_upd = 1'b1;
        rd_b_nxt   = 1'b0;
        wimm_nxt   = 1'b0;
        if (!active) begin
          state_nxt = S_IPUP;
        end else if (movi) begin
          state_nxt = S_MVI;
        end else if (need_a) begin
          state_nxt = S_O0;
        end else begin
          state_nxt = S_EX;
        end
      end
      S_MVI: begin
        // Move of the immediate also stores it at that address for m above 4.
        cmd.ridx   = stat.m;
        cmd.rf_we  = 1'b1;
        cmd.rf_imm = 1'b1;
        if (stat.m > REG_DIRECT_MAX) begin
          wimm_nxt  = 1'b1;
          state_nxt = S_W0;
        end else begin
          state_nxt = S_IPUP;
        end
      end
      S_O0: begin
        cmd.ridx      = opnd_idx;
        cmd.maddr_sel = MA_REG;
        if (opnd_idx <= REG_DIRECT_MAX) begin
          cmd.cap   = rd_b_r ? CAP_BREG : CAP_AREG;
          rd_b_nxt  = 1'b1;
          state_nxt = after_opnd;
        end else begin
          state_nxt = S_O1;
        end
      end
      S_O1: begin
        cmd.ridx      = opnd_idx;
        cmd.maddr_sel = MA_REG;
        cmd.moff      = 2'd1;
        cmd.cap       = rd_b_r ? CAP_BHI : CAP_AHI;
        state_nxt     = S_O2;
      end
      S_O2: begin
        cmd.cap   = rd_b_r ? CAP_BLO : CAP_ALO;
        rd_b_nxt  = 1'b1;
        state_nxt = after_opnd;
      end
      S_EX: begin
        if (is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DV;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = need_wb ? S_W0 : S_IPUP;
        end
      end
      S_DV: begin
        if (stat.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = S_W0;
        end
      end
      S_W0: begin
        cmd.ridx = dst_idx;
        if (wimm_r) begin
          cmd.maddr_sel = MA_IMM;
          cmd.mwe       = 1'b1;
          cmd.wsel      = WD_HI;
          state_nxt     = S_W1;
        end else if (dst_idx <= REG_DIRECT_MAX) begin
          cmd.rf_we = 1'b1;
          state_nxt = S_IPUP;
        end else begin
          cmd.maddr_sel = MA_REG;
          cmd.mwe       = 1'b1;
          cmd.wsel      = WD_HI;
          state_nxt     = S_W1;
        end
      end
      S_W1: begin
        cmd.ridx      = dst_idx;
        cmd.maddr_sel = wimm_r ? MA_IMM : MA_REG;
        cmd.moff      = 2'd1;
        cmd.mwe       = 1'b1;
        cmd.wsel      = WD_LO;
        state_nxt     = S_IPUP;
      end
      S_IPUP: begin
        cmd.ip_upd = 1'b1;
        state_nxt  = S_RES;
      end
      S_RES: begin
        cmd.ridx = k_idx;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          k_nxt        = k_r + 3'd1;
          if (k_r == 3'd7) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      rd_b_r  <= 1'b0;
      wimm_r  <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      rd_b_r  <= rd_b_nxt;
      wimm_r  <= wimm_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// ===== src/tcd_dp.sv =====
// Datapath of the toy CPU: byte memory, register file, ip/flag/ir, ALU,
// divider and the result output register. Uses tcd_pkg, tcd_ram, tcd_div.
module tcd_dp import tcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [15:0] plen,
  input  logic [14:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  input  logic [15:0] in_in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [71:0] out_data,
  output logic        out_last
);

  logic [15:0] rf_r [9];
  logic [15:0] rf_rdata, rf_wdata;
  logic [7:0]  op_r, rb_r;
  logic [15:0] imm_r, a_r, b_r, res_r;
  logic [15:0] ip_r, ir_r, in_val_r;
  logic [1:0]  flag_r, cmp_flag;
  logic [14:0] ld_addr_r;
  logic [7:0]  ld_byte_r;
  logic        outv_r;
  logic [15:0] outw_r;
  logic [MEM_AW:0] clr_cnt_r;

  logic [15:0]       mbase, msum, b_opnd, alu_res, div_q;
  logic [MEM_AW-1:0] maddr;
  logic [7:0]        mwdata, mrdata;
  logic              take, finished, div_done;

  logic        oval_r, olast_r;
  logic [71:0] odata_r;

  // Register file read at one controller-chosen index.
  always_comb begin
    rf_rdata = '0;
    for (int i = 0; i < 9; i++) begin
      if (cmd.ridx == 4'(i)) begin
        rf_rdata = rf_r[i];
      end
    end
  end

  assign rf_wdata = cmd.rf_imm ? imm_r : res_r;

  always_comb begin
    case (cmd.maddr_sel)
      MA_PC:   mbase = ip_r;
      MA_REG:  mbase = rf_rdata;
      MA_IMM:  mbase = imm_r;
      MA_LOAD: mbase = {1'b0, ld_addr_r};
      default: mbase = '0;
    endcase
  end

  assign msum  = mbase + {14'd0, cmd.moff};
  assign maddr = (cmd.maddr_sel == MA_CLR) ? clr_cnt_r[MEM_AW-1:0] : msum[MEM_AW-1:0];

  always_comb begin
    case (cmd.wsel)
      WD_LOAD: mwdata = ld_byte_r;
      WD_HI:   mwdata = res_r[15:8];
      WD_LO:   mwdata = res_r[7:0];
      default: mwdata = 8'd0;
    endcase
  end

  tcd_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .we    (cmd.mwe),
    .addr  (maddr),
    .wdata (mwdata),
    .rdata (mrdata)
  );

  assign b_opnd = cmd.b_imm ? imm_r : b_r;

  tcd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (a_r),
    .divisor  (b_opnd),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (op_r)
      OP_ADD:  alu_res = a_r + b_opnd;
      OP_SUB:  alu_res = a_r - b_opnd;
      OP_MUL:  alu_res = a_r * b_opnd;
      OP_AND:  alu_res = {15'd0, (a_r != 16'd0) && (b_opnd != 16'd0)};
      OP_OR:   alu_res = {15'd0, (a_r != 16'd0) || (b_opnd != 16'd0)};
      OP_NOT:  alu_res = {15'd0, a_r == 16'd0};
      OP_IN:   alu_res = in_val_r;
      default: alu_res = a_r;
    endcase
  end

  always_comb begin
    if ($signed(a_r) < $signed(b_opnd)) begin
      cmp_flag = FLAG_LT;
    end else if ($signed(a_r) > $signed(b_opnd)) begin
      cmp_flag = FLAG_GT;
    end else begin
      cmp_flag = FLAG_EQ;
    end
  end

  assign take = (op_r == OP_JMP) &&
                ((rb_r[3:0] == JC_ALWAYS) ||
                 ((rb_r[3:0] == JC_EQ) && (flag_r == FLAG_EQ)) ||
                 ((rb_r[3:0] == JC_GT) && (flag_r == FLAG_GT)) ||
                 ((rb_r[3:0] == JC_LT) && (flag_r == FLAG_LT)));

  // ip is signed, the program length unsigned.
  assign finished = $signed({ip_r[15], ip_r}) >= $signed({1'b0, plen});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        rf_r[i] <= '0;
      end
      ip_r      <= '0;
      flag_r    <= FLAG_EQ;
      ir_r      <= '0;
      outv_r    <= 1'b0;
      outw_r    <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.clr_inc) begin
        clr_cnt_r <= clr_cnt_r + {{MEM_AW{1'b0}}, 1'b1};
      end
      if (cmd.rf_we) begin
        for (int i = 0; i < 9; i++) begin
          if (cmd.ridx == 4'(i)) begin
            rf_r[i] <= rf_wdata;
          end
        end
      end
      if (cmd.step_clr) begin
        outv_r <= 1'b0;
        outw_r <= '0;
      end
      if (cmd.ir_upd) begin
        ir_r <= (op_r == OP_NOP) ? 16'd0 : {op_r, rb_r};
      end
      if (cmd.ip_upd) begin
        ip_r <= ip_r + (take ? imm_r : 16'd4);
      end
      if (cmd.exec && (op_r == OP_CMP)) begin
        flag_r <= cmp_flag;
      end
      if (cmd.exec && (op_r == OP_OUT)) begin
        outv_r <= 1'b1;
        outw_r <= a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      ld_addr_r <= in_load_address;
      ld_byte_r <= in_load_byte;
      in_val_r  <= in_in_value;
    end
    case (cmd.cap)
      CAP_OP:   op_r        <= mrdata;
      CAP_RB:   rb_r        <= mrdata;
      CAP_IHI:  imm_r[15:8] <= mrdata;
      CAP_ILO:  imm_r[7:0]  <= mrdata;
      CAP_AREG: a_r         <= rf_rdata;
      CAP_AHI:  a_r[15:8]   <= mrdata;
      CAP_ALO:  a_r[7:0]    <= mrdata;
      CAP_BREG: b_r         <= rf_rdata;
      CAP_BHI:  b_r[15:8]   <= mrdata;
      CAP_BLO:  b_r[7:0]    <= mrdata;
      default: ;
    endcase
    if (cmd.exec) begin
      res_r <= alu_res;
    end else if (cmd.div_cap) begin
      res_r <= div_q;
    end else if (cmd.rf_imm) begin
      res_r <= imm_r;
    end
  end

  // Output register: one result beat per reported register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (cmd.out_load) begin
      oval_r <= 1'b1;
    end else if (out_ready) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      odata_r <= {finished, outw_r, outv_r, rf_rdata, cmd.ridx, ir_r, flag_r, ip_r};
      olast_r <= (cmd.ridx == REG_MAX);
    end
  end

  assign out_valid = oval_r;
  assign out_data  = odata_r;
  assign out_last  = olast_r;

  assign stat.op       = op_r;
  assign stat.m        = rb_r[7:4];
  assign stat.n        = rb_r[3:0];
  assign stat.finished = finished;
  assign stat.clr_done = clr_cnt_r[MEM_AW];
  assign stat.div_done = div_done;
  assign stat.out_free = !oval_r || out_ready;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for toy_cpu_instruction_executor: loads programs, runs steps and checks
// every register result beat against a built-in model of the CPU.
// Depends on tcd_pkg and the RTL of the block only.
module tb_top;
  import tcd_pkg::*;

  typedef struct packed {
    logic [15:0] ip_now;
    logic [1:0]  flag_now;
    logic [15:0] ir_now;
    logic [3:0]  reg_number;
    logic [15:0] reg_value;
    logic        out_valid;
    logic [15:0] out_value;
    logic        finished;
    logic        last;
  } reg_report_t;

  localparam int STALL_LIMIT = 100000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // load_address, load_byte, in_value, pad
  logic        in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // ip_now, flag_now, ir_now, reg_number,
                           // reg_value, out_valid, out_value, finished
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  toy_cpu_instruction_executor u_top (.*);

  // Model state of the CPU.
  logic [7:0]         mem_img [0:MEM_BYTES-1];
  logic signed [15:0] gpr [0:8];
  logic [15:0]        ip_q;
  logic [1:0]         flag_q;
  logic [15:0]        ir_q;
  logic [15:0]        plen_q;

  reg_report_t pending_reports [$];
  int          errors;
  int          loads_sent;
  int          steps_sent;
  int          beats_checked;
  int          outputs_seen;
  int          stall_cycles;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic logic signed [15:0] word_at(input logic [15:0] a);
    return {mem_img[a[14:0]], mem_img[a[14:0] + 15'd1]};
  endfunction

  function automatic void word_put(input logic [15:0] a, input logic [15:0] v);
    mem_img[a[14:0]]         = v[15:8];
    mem_img[a[14:0] + 15'd1] = v[7:0];
  endfunction

  function automatic logic signed [15:0] opnd_get(input logic [3:0] r);
    if (r <= REG_DIRECT_MAX) return gpr[r];
    return word_at(gpr[r]);
  endfunction

  function automatic void opnd_put(input logic [3:0] r, input logic [15:0] v);
    if (r <= REG_DIRECT_MAX) gpr[r] = v;
    else word_put(gpr[r], v);
  endfunction

  function automatic logic signed [15:0] alu(input logic [7:0] op,
                                             input logic signed [15:0] a,
                                             input logic signed [15:0] b);
    case (op)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_DIV: begin
        if (b == 0) return 16'sd0;
        if (a == -16'sd32768 && b == -16'sd1) return a;
        return a / b;
      end
      OP_AND: return (a != 0 && b != 0) ? 16'sd1 : 16'sd0;
      OP_OR:  return (a != 0 || b != 0) ? 16'sd1 : 16'sd0;
      default: return (a == 0) ? 16'sd1 : 16'sd0;
    endcase
  endfunction

  function automatic bit cpu_finished();
    return int'($signed(ip_q)) >= int'(plen_q);
  endfunction

  // Executes one instruction on the model and queues the eight register reports.
  function automatic void execute_step(input logic [15:0] in_word);
    logic [7:0]         op;
    logic [7:0]         rb;
    logic [3:0]         m;
    logic [3:0]         n;
    logic signed [15:0] imm;
    logic [15:0]        advance;
    logic               take;
    logic               ov;
    logic [15:0]        ow;
    reg_report_t        rr;
    ov = 1'b0;
    ow = '0;
    if (!cpu_finished()) begin
      op      = mem_img[ip_q[14:0]];
      rb      = mem_img[ip_q[14:0] + 15'd1];
      m       = rb[7:4];
      n       = rb[3:0];
      imm     = word_at(ip_q + 16'd2);
      advance = 16'd4;
      ir_q    = (op == OP_NOP) ? 16'd0 : {op, rb};
      if (op >= OP_MOV && op <= OP_OUT && op != OP_JMP && (m > REG_MAX || n > REG_MAX)) begin
        // A register nibble out of range makes the instruction a no-op.
      end else if (op == OP_MOV) begin
        if (n == 0) begin
          gpr[m] = imm;
          if (m > REG_DIRECT_MAX) word_put(imm, imm);
        end else begin
          opnd_put(m, opnd_get(n));
        end
      end else if (op >= OP_ADD && op <= OP_NOT) begin
        if (op >= OP_AND && m == 0 && n != 0)
          opnd_put(n, alu(op, opnd_get(n), imm));
        else
          opnd_put(m, alu(op, opnd_get(m), (n == 0) ? imm : opnd_get(n)));
      end else if (op == OP_CMP) begin
        if (opnd_get(m) < ((n == 0) ? imm : opnd_get(n))) flag_q = FLAG_LT;
        else if (opnd_get(m) > ((n == 0) ? imm : opnd_get(n))) flag_q = FLAG_GT;
        else flag_q = FLAG_EQ;
      end else if (op == OP_JMP) begin
        take = (n == JC_ALWAYS) || (n == JC_EQ && flag_q == FLAG_EQ) ||
               (n == JC_GT && flag_q == FLAG_GT) || (n == JC_LT && flag_q == FLAG_LT);
        if (take) advance = imm;
      end else if (op == OP_IN) begin
        opnd_put(m, in_word);
      end else if (op == OP_OUT) begin
        ov = 1'b1;
        ow = opnd_get(m);
      end
      ip_q = ip_q + advance;
    end
    for (int k = 1; k <= 8; k++) begin
      rr.ip_now     = ip_q;
      rr.flag_now   = flag_q;
      rr.ir_now     = ir_q;
      rr.reg_number = 4'(k);
      rr.reg_value  = gpr[k];
      rr.out_valid  = ov;
      rr.out_value  = ow;
      rr.finished   = cpu_finished();
      rr.last       = (k == 8);
      pending_reports.push_back(rr);
    end
    if (ov) outputs_seen++;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    reg_report_t got;
    reg_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[17:16], out_tdata[33:18], out_tdata[37:34],
             out_tdata[53:38], out_tdata[54], out_tdata[70:55], out_tdata[71], out_tlast};
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected beat, reg", 16'(got.reg_number), 16'd0);
      end else begin
        want = pending_reports.pop_front();
        beats_checked++;
        if (got.ip_now != want.ip_now) report_mismatch("ip_now", got.ip_now, want.ip_now);
        if (got.flag_now != want.flag_now)
          report_mismatch("flag_now", 16'(got.flag_now), 16'(want.flag_now));
        if (got.ir_now != want.ir_now) report_mismatch("ir_now", got.ir_now, want.ir_now);
        if (got.reg_number != want.reg_number)
          report_mismatch("reg_number", 16'(got.reg_number), 16'(want.reg_number));
        if (got.reg_value != want.reg_value)
          report_mismatch("reg_value", got.reg_value, want.reg_value);
        if (got.out_valid != want.out_valid)
          report_mismatch("out_valid", 16'(got.out_valid), 16'(want.out_valid));
        if (got.out_value != want.out_value)
          report_mismatch("out_value", got.out_value, want.out_value);
        if (got.finished != want.finished)
          report_mismatch("finished", 16'(got.finished), 16'(want.finished));
        if (got.last != want.last) report_mismatch("tlast", 16'(got.last), 16'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= calm || ($urandom_range(99) >= 38);
  end

  // Ends the run if no beat moves for too long; this covers the memory clear too.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_item(input bit mode, input logic [14:0] addr,
                           input logic [7:0] data, input logic [15:0] in_word);
    while (!calm && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {1'b0, in_word, data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode) begin
      execute_step(in_word);
      steps_sent++;
    end else begin
      mem_img[addr] = data;
      loads_sent++;
    end
  endtask

  task automatic put_instr(input logic [14:0] addr, input logic [7:0] op,
                           input logic [7:0] rb, input logic [15:0] imm);
    send_item(1'b0, addr, op, 16'($urandom));
    send_item(1'b0, addr + 15'd1, rb, 16'($urandom));
    send_item(1'b0, addr + 15'd2, imm[15:8], 16'($urandom));
    send_item(1'b0, addr + 15'd3, imm[7:0], 16'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Writes program_length once the block is idle; a trailing load gets time to land.
  task automatic write_program_length(input logic [15:0] value);
    wait_drained();
    repeat (80) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_PROGRAM_LENGTH, 2'b00};
    cfg_pwdata  <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    plen_q = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_opcode();
    int r;
    r = $urandom_range(99);
    if (r < 4) return OP_NOP;
    if (r < 8) return 8'($urandom_range(255, 13));
    return 8'($urandom_range(12, 1));
  endfunction

  function automatic logic [7:0] pick_regs(input logic [7:0] op);
    logic [3:0] m;
    logic [3:0] n;
    m = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    n = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    if (op == OP_JMP) n = ($urandom_range(99) < 85) ? 4'($urandom_range(3)) : 4'($urandom);
    return {m, n};
  endfunction

  function automatic logic [15:0] pick_imm(input logic [7:0] op);
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return (op == OP_JMP) ? 16'(4 * $urandom_range(4)) : 16'($urandom_range(16));
      2: return (op == OP_JMP) ? 16'(-4 * $urandom_range(3)) : 16'h4000 + 16'($urandom_range(64));
      default: return ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_zero_length();
    write_program_length(16'd0);
    repeat (2) send_item(1'b1, 15'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic test_directed_program();
    logic [7:0]  ops [26] = '{OP_MOV, OP_MOV, OP_DIV, OP_MOV, OP_DIV, OP_MOV, OP_ADD, OP_MUL,
                              OP_SUB, OP_AND, OP_OR, OP_NOT, OP_CMP, OP_JMP, 8'd200, OP_CMP,
                              OP_JMP, OP_JMP, OP_JMP, OP_JMP, OP_ADD, OP_IN, OP_IN, OP_OUT,
                              OP_OUT, 8'd255};
    logic [7:0]  rbs [26] = '{8'h10, 8'h20, 8'h12, 8'h30, 8'h30, 8'h50, 8'h45, 8'h40,
                              8'h40, 8'h04, 8'h35, 8'h20, 8'h10, 8'h03, 8'h00, 8'h43,
                              8'h01, 8'h02, 8'h07, 8'h00, 8'h9A, 8'h60, 8'h10, 8'h60,
                              8'h10, 8'h00};
    logic [15:0] imms [26] = '{16'h8000, 16'hFFFF, 16'h0, 16'd7, 16'h0, 16'h7FFF, 16'h0,
                               16'd300, 16'h7FFF, 16'd5, 16'h0, 16'h0, 16'h0, 16'd8,
                               16'h0, 16'h0, 16'd8, 16'd8, 16'd8, 16'd4, 16'h0, 16'h0,
                               16'h0, 16'h0, 16'h0, 16'h0};
    logic [15:0] in_words [2] = '{16'h8000, 16'h7FFF};
    int ins;
    for (int i = 0; i < 26; i++) put_instr(15'(4 * i), ops[i], rbs[i], imms[i]);
    write_program_length(16'd104);
    ins = 0;
    // Extra steps past the end show the finished behavior.
    for (int i = 0; i < 30; i++) begin
      send_item(1'b1, 15'($urandom), 8'($urandom), in_words[ins % 2]);
      ins++;
    end
    send_item(1'b0, 15'h7FFF, 8'hFF, 16'($urandom));
  endtask

  // Places a fresh program where ip now points and runs it for a while.
  task automatic run_random_program(input int count, input bit endless);
    logic [14:0] base;
    logic [7:0]  op;
    int          ip_int;
    base   = ip_q[14:0];
    ip_int = int'($signed(ip_q));
    for (int i = 0; i < count; i++) begin
      op = pick_opcode();
      put_instr(base + 15'(4 * i), op, pick_regs(op), pick_imm(op));
    end
    if ($urandom_range(99) < 10)
      send_item(1'b0, 15'($urandom), 8'($urandom), 16'($urandom));
    if (endless || ip_int < 0 || ip_int + 4 * count > 32767)
      write_program_length(16'h8000);
    else
      write_program_length(16'(ip_int + 4 * count));
    for (int i = 0; i < count + 3; i++) begin
      if ($urandom_range(99) < 5)
        send_item(1'b0, 15'($urandom), 8'($urandom), 16'($urandom));
      send_item(1'b1, 15'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_random_programs(input int phases);
    for (int p = 0; p < phases; p++) run_random_program($urandom_range(8, 2), p % 7 == 3);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++) send_item(1'b1, 15'd0, 8'd0, 16'($urandom));
    wait_drained();
    for (int i = 0; i < 4; i++) send_item(1'b1, 15'd0, 8'd0, 16'($urandom));
  endtask

  task automatic test_no_idle();
    calm = 1'b1;
    test_random_programs(2);
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < MEM_BYTES; i++) mem_img[i] = 8'd0;
    for (int i = 0; i <= 8; i++) gpr[i] = 16'sd0;
    ip_q   = '0;
    flag_q = FLAG_EQ;
    ir_q   = '0;
    plen_q = '0;
    errors = 0;
    calm   = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_length();
    test_directed_program();
    test_random_programs(4);
    test_drain_pause();
    test_no_idle();
    test_random_programs(4);

    wait_drained();
    repeat (100) @(posedge clk);
    $display("Ran %0d steps and %0d program loads; %0d register beats checked.",
             steps_sent, loads_sent, beats_checked);
    $display("Output instructions seen: %0d, plus length settings 0 and 32768.", outputs_seen);
    if (errors == 0 && pending_reports.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
